FILE: rtl/core/rfc_pkg.sv
// Shared types and constants for the response frame checker.
// Used by every module of the block and by its checker.
package rfc_pkg;

   localparam int FRAME_MAX_DEF = 64;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int PLEN_W   = 6;
   localparam int RSP_DATA_W = 24;   // 8 + 3 + 6 = 17, padded to whole bytes

   // Frame delimiters and checksum seed
   localparam logic [7:0] CHK_SEED = 8'h55;
   localparam logic [7:0] HDR0     = 8'h3E;   // '>'
   localparam logic [7:0] HDR1     = 8'h5B;   // '['
   localparam logic [7:0] FTR0     = 8'h5D;   // ']'
   localparam logic [7:0] FTR1     = 8'h3C;   // '<'
   localparam int         MIN_FRAME = 8;

   // Fixed byte positions within a frame
   localparam int POS_HDR0   = 0;
   localparam int POS_HDR1   = 1;
   localparam int POS_OPCODE = 2;
   localparam int POS_SUB    = 3;
   localparam int POS_LEN    = 4;
   localparam int POS_PAY    = 5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FORMAT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ID       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd4;

   // Register indexes
   localparam logic REG_OPCODE  = 1'b0;
   localparam logic REG_SUBCODE = 1'b1;

   // Check results gathered at frame end, evaluated in priority order later
   typedef struct packed {
      logic over;
      logic fmt_bad;
      logic id_bad;
      logic len_bad;
      logic chk_bad;
   } rfc_check_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              payload;
      logic              done;
      rfc_check_type     chk;
      logic [PLEN_W-1:0] plen;
   } rfc_item_type;

endpackage

FILE: rtl/core/rfc_front.sv
// Front end: holds the frame state and the csr registers, classifies each byte.
// Depends on rfc_pkg.
module rfc_front import rfc_pkg::*; #(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [BYTE_W-1:0]   csr_wdata,
   input  logic                beat_in,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic                frame_end,
   output rfc_item_type        item
);

   localparam int CW = $clog2(FRAME_MAX + 2);
   localparam int XW = 10;

   logic [BYTE_W-1:0] opcode_ff, subcode_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic              hdr_ff, hdr_in;
   logic              id_ff, id_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] prev_ff;

   logic [XW-1:0]     p, n;
   logic              in_range;
   logic [BYTE_W-1:0] want;

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff  <= '0;
         subcode_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OPCODE:  opcode_ff  <= csr_wdata;
            REG_SUBCODE: subcode_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      p        = XW'(count_ff);
      in_range = p < XW'(FRAME_MAX);
      hdr_in   = hdr_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      xor_in   = xor_ff;
      if (in_range) begin
         if (p == XW'(POS_HDR0) && rx_byte != HDR0) hdr_in = 1'b0;
         if (p == XW'(POS_HDR1) && rx_byte != HDR1) hdr_in = 1'b0;
         if (p == XW'(POS_OPCODE) && rx_byte != opcode_ff) id_in = 1'b0;
         if (p == XW'(POS_SUB) && rx_byte != subcode_ff) id_in = 1'b0;
         if (p == XW'(POS_LEN)) len_in = rx_byte;
         if (p >= XW'(POS_LEN)) xor_in = xor_ff ^ rx_byte;
      end
      // saturates one past the limit so an overlong frame stays visible
      count_in = (p <= XW'(FRAME_MAX)) ? count_ff + CW'(1) : count_ff;
      n        = XW'(count_in);
      want     = CHK_SEED ^ opcode_ff ^ subcode_ff;

      item.data    = rx_byte;
      item.payload = in_range && p >= XW'(POS_PAY) && p <= XW'(len_ff) + XW'(POS_LEN);
      item.done    = frame_end;
      item.chk.over    = n > XW'(FRAME_MAX);
      item.chk.fmt_bad = n < XW'(MIN_FRAME) || !hdr_in || prev_ff != FTR0
                         || rx_byte != FTR1;
      item.chk.id_bad  = !id_in;
      item.chk.len_bad = XW'(len_in) + XW'(MIN_FRAME) != n;
      item.chk.chk_bad = (xor_in ^ prev_ff ^ rx_byte) != want;
      item.plen        = len_in[PLEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hdr_ff   <= 1'b1;
         id_ff    <= 1'b1;
         len_ff   <= '0;
         xor_ff   <= '0;
         prev_ff  <= '0;
      end else if (beat_in) begin
         if (frame_end) begin
            count_ff <= '0;
            hdr_ff   <= 1'b1;
            id_ff    <= 1'b1;
            len_ff   <= '0;
            xor_ff   <= '0;
            prev_ff  <= '0;
         end else begin
            count_ff <= count_in;
            hdr_ff   <= hdr_in;
            id_ff    <= id_in;
            len_ff   <= len_in;
            xor_ff   <= xor_in;
            prev_ff  <= rx_byte;
         end
      end
   end

endmodule

FILE: rtl/core/rfc_queue.sv
// Two-entry queue of classified bytes between front and back end.
// Depends on rfc_pkg.
module rfc_queue import rfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rfc_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output rfc_item_type head
);

   rfc_item_type slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/core/rfc_back.sv
// Back end: resolves the status by priority and holds the result register.
// Depends on rfc_pkg.
module rfc_back import rfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  rfc_item_type          q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic                valid_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic                payload_ff, done_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;

   assign q_pop = q_not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      status_in = ST_OK;
      plen_in   = '0;
      if (q_head.done) begin
         if (q_head.chk.over)         status_in = ST_SIZE;
         else if (q_head.chk.fmt_bad) status_in = ST_FORMAT;
         else if (q_head.chk.id_bad)  status_in = ST_ID;
         else if (q_head.chk.len_bad) status_in = ST_SIZE;
         else if (q_head.chk.chk_bad) status_in = ST_CHECKSUM;
         else                         plen_in   = q_head.plen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff    <= q_head.data;
         payload_ff <= q_head.payload;
         done_ff    <= q_head.done;
         status_ff  <= status_in;
         plen_ff    <= plen_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - BYTE_W - STATUS_W - PLEN_W)'(0), plen_ff, status_ff, data_ff};
   assign rsp_tuser  = payload_ff;
   assign rsp_tlast  = done_ff;

endmodule

FILE: rtl/core/response_frame_checker_top.sv
// Top level of the response frame checker: front end, queue, back end.
// Depends on rfc_pkg, rfc_front, rfc_queue and rfc_back.
//
// Takes one frame byte per beat and returns one beat per byte: the byte
// echoed, a payload flag, and on the frame-end byte a status and payload
// length. A byte is accepted every cycle while the queue is not full; each
// goes through the queue and then the output register to its result beat,
// and the two-entry queue lets the input side keep going for two more bytes
// while the result side is stalled. The checksum uses the csr values at the
// time the frame-end byte is taken, opcode and subcode the values when
// their bytes arrive; write the csr registers only between frames.
module response_frame_checker_top import rfc_pkg::*; #(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // [7:0] rx_byte
   input  logic                  req_tlast,    // frame_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [7:0] echo_byte, [10:8] frame_status,
                                               // [16:11] payload_length, rest zero
   output logic                  rsp_tuser,    // is_payload
   output logic                  rsp_tlast     // frame_done
);

   rfc_item_type front_item, q_head;
   logic         q_full, q_not_empty, q_pop, beat_in;

   assign req_tready = !q_full;
   assign beat_in    = req_tvalid && req_tready;

   rfc_front #(.FRAME_MAX(FRAME_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .beat_in   (beat_in),
      .rx_byte   (req_tdata),
      .frame_end (req_tlast),
      .item      (front_item)
   );

   rfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (beat_in),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: rtl/core/rfc_checker.sv
// Port-level assertions for the response frame checker, bound to the top level.
// Depends on rfc_pkg and response_frame_checker_top.
module rfc_checker import rfc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   logic [STATUS_W-1:0] status;
   logic [PLEN_W-1:0]   plen;

   assign status = rsp_tdata[10:8];
   assign plen   = rsp_tdata[16:11];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> status == ST_OK && plen == '0)
      else $error("status or length on a non-final byte");

   a_len_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ST_OK |-> plen == '0)
      else $error("payload length reported on a failed frame");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status == ST_OK || status == ST_SIZE || status == ST_FORMAT
                     || status == ST_ID || status == ST_CHECKSUM)
      else $error("undefined status code");

endmodule

bind response_frame_checker_top rfc_checker u_rfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
